>>> rtl/hrsp_pkg.sv
package hrsp_pkg;

  localparam int unsigned OFFSET_WIDTH_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned SPAN_OFF_W = 16;

  localparam logic [3:0] K_METHOD = 4'd0;
  localparam logic [3:0] K_URL    = 4'd1;
  localparam logic [3:0] K_QKEY   = 4'd2;
  localparam logic [3:0] K_QVAL   = 4'd3;
  localparam logic [3:0] K_PROTO  = 4'd4;
  localparam logic [3:0] K_VER    = 4'd5;
  localparam logic [3:0] K_HKEY   = 4'd6;
  localparam logic [3:0] K_HVAL   = 4'd7;
  localparam logic [3:0] K_BODY   = 4'd8;
  localparam logic [3:0] K_LERR   = 4'd9;
  localparam logic [3:0] K_HERR   = 4'd10;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [20:0] {
    PH_PRE       = 21'h000001,
    PH_METHOD    = 21'h000002,
    PH_PRE_URL   = 21'h000004,
    PH_URL       = 21'h000008,
    PH_QSTART    = 21'h000010,
    PH_QKEY      = 21'h000020,
    PH_QVAL0     = 21'h000040,
    PH_QVAL      = 21'h000080,
    PH_PRE_PROTO = 21'h000100,
    PH_PROTO     = 21'h000200,
    PH_VER0      = 21'h000400,
    PH_VER       = 21'h000800,
    PH_RL_LF     = 21'h001000,
    PH_H_START   = 21'h002000,
    PH_HKEY      = 21'h004000,
    PH_PRE_HVAL  = 21'h008000,
    PH_HVAL      = 21'h010000,
    PH_H_LF      = 21'h020000,
    PH_H_END_LF  = 21'h040000,
    PH_BODY      = 21'h080000,
    PH_DONE      = 21'h100000
  } phase_e;

  typedef struct packed {
    logic [3:0]            kind;
    logic [SPAN_OFF_W-1:0] span_begin;
    logic [SPAN_OFF_W-1:0] span_end;
    logic                  fin;
  } span_t;

  typedef struct packed {
    logic  two;
    span_t ev0;
    span_t ev1;
  } rec_t;

endpackage

>>> rtl/hrsp_in_if.sv
interface hrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

>>> rtl/hrsp_out_if.sv
interface hrsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  span_kind;
  logic [15:0] span_begin;
  logic [15:0] span_end;
  logic        final_event;

  modport source (output valid, output span_kind, output span_begin, output span_end,
                  output final_event, input ready);
  modport sink   (input valid, input span_kind, input span_begin, input span_end,
                  input final_event, output ready);
endinterface

>>> rtl/hrsp_front.sv
module hrsp_front #(
  parameter int unsigned OFFSET_WIDTH = hrsp_pkg::OFFSET_WIDTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hrsp_in_if.sink       req_i,
  input  logic          push_ready_i,
  output logic          push_valid_o,
  output hrsp_pkg::rec_t push_rec_o
);
  import hrsp_pkg::*;

  localparam int unsigned OW = OFFSET_WIDTH;
  localparam logic [OW-1:0] OFF_MAX = {OW{1'b1}};
  localparam logic [OW-1:0] OFF_ONE = {{(OW-1){1'b0}}, 1'b1};

  phase_e        phase_q, phase_d;
  logic [OW-1:0] off_q, off_d;
  logic [OW-1:0] tok_q, tok_d;
  logic [OW-1:0] lnb_q, lnb_d;

  phase_e        ph_t;
  logic [OW-1:0] tok_t, lnb_t, off_n;
  logic          a_v, a_f, b_v, fail_t, sat, accept;
  logic [3:0]    a_k, b_k;
  logic [OW-1:0] a_b, a_e, b_b, b_e;
  logic          bl, crlf;
  logic [7:0]    c;
  logic [OW+SPAN_OFF_W-1:0] a_b_x, a_e_x, b_b_x, b_e_x;
  span_t         ev_a, ev_b;

  function automatic logic line_phase(phase_e p);
    logic r;
    case (p)
      PH_PRE, PH_METHOD, PH_PRE_URL, PH_URL, PH_QSTART, PH_QKEY, PH_QVAL0, PH_QVAL,
      PH_PRE_PROTO, PH_PROTO, PH_VER0, PH_VER, PH_RL_LF: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  assign c      = req_i.data_byte;
  assign bl     = (c == CH_SP) || (c == CH_TAB);
  assign crlf   = (c == CH_CR) || (c == CH_LF);
  assign sat    = (off_q == OFF_MAX);
  assign accept = req_i.valid && push_ready_i;
  assign req_i.ready = push_ready_i;

  always_comb begin
    ph_t   = phase_q;
    tok_t  = tok_q;
    lnb_t  = lnb_q;
    off_n  = off_q;
    a_v    = 1'b0;
    a_k    = K_METHOD;
    a_b    = tok_q;
    a_e    = off_q;
    a_f    = 1'b0;
    fail_t = 1'b0;
    if (sat) begin
      if (phase_q != PH_DONE) begin
        a_v  = 1'b1;
        a_k  = K_HERR;
        a_b  = off_q;
        a_f  = 1'b1;
        ph_t = PH_DONE;
      end
    end else begin
      off_n = off_q + OFF_ONE;
      case (phase_q)
        PH_PRE: begin
          if (!bl) begin
            if (c >= CH_A && c <= CH_Z) begin
              tok_t = off_q;
              ph_t  = PH_METHOD;
            end else begin
              fail_t = 1'b1;
            end
          end
        end
        PH_METHOD: begin
          if (bl) begin
            a_v  = 1'b1;
            a_k  = K_METHOD;
            ph_t = PH_PRE_URL;
          end
        end
        PH_PRE_URL: begin
          if (!bl) begin
            if (crlf) begin
              fail_t = 1'b1;
            end else if (c == CH_QUEST) begin
              a_v  = 1'b1;
              a_k  = K_URL;
              a_b  = off_q;
              ph_t = PH_QSTART;
            end else begin
              tok_t = off_q;
              ph_t  = PH_URL;
            end
          end
        end
        PH_URL: begin
          if (bl || c == CH_QUEST) begin
            a_v  = 1'b1;
            a_k  = K_URL;
            ph_t = bl ? PH_PRE_PROTO : PH_QSTART;
          end
        end
        PH_QSTART: begin
          if (crlf || c == CH_EQ) begin
            fail_t = 1'b1;
          end else if (bl) begin
            ph_t = PH_PRE_PROTO;
          end else begin
            tok_t = off_q;
            ph_t  = PH_QKEY;
          end
        end
        PH_QKEY: begin
          if (c == CH_EQ) begin
            a_v   = 1'b1;
            a_k   = K_QKEY;
            tok_t = off_q + OFF_ONE;
            ph_t  = PH_QVAL0;
          end
        end
        PH_QVAL0: begin
          if (bl || c == CH_AMP) fail_t = 1'b1;
          else ph_t = PH_QVAL;
        end
        PH_QVAL: begin
          if (bl || c == CH_AMP) begin
            a_v  = 1'b1;
            a_k  = K_QVAL;
            ph_t = bl ? PH_PRE_PROTO : PH_QSTART;
          end
        end
        PH_PRE_PROTO: begin
          if (!bl) begin
            if (c == CH_H) begin
              tok_t = off_q;
              ph_t  = PH_PROTO;
            end else begin
              fail_t = 1'b1;
            end
          end
        end
        PH_PROTO: begin
          if (c == CH_SLASH) begin
            a_v  = 1'b1;
            a_k  = K_PROTO;
            ph_t = PH_VER0;
          end
        end
        PH_VER0: begin
          if (c >= CH_0 && c <= CH_9) begin
            tok_t = off_q;
            ph_t  = PH_VER;
          end else begin
            fail_t = 1'b1;
          end
        end
        PH_VER: begin
          if (c == CH_CR) begin
            a_v  = 1'b1;
            a_k  = K_VER;
            ph_t = PH_RL_LF;
          end
        end
        PH_RL_LF: begin
          if (c == CH_LF) ph_t = PH_H_START;
          else fail_t = 1'b1;
        end
        PH_H_START: begin
          if (!bl) begin
            if (c == CH_CR) begin
              ph_t = PH_H_END_LF;
            end else if (c == CH_LF) begin
              fail_t = 1'b1;
            end else begin
              tok_t = off_q;
              lnb_t = off_q;
              ph_t  = PH_HKEY;
            end
          end
        end
        PH_HKEY: begin
          if (c == CH_COLON) begin
            a_v  = 1'b1;
            a_k  = K_HKEY;
            a_e  = lnb_q + OFF_ONE;
            ph_t = PH_PRE_HVAL;
          end else if (!bl) begin
            lnb_t = off_q;
          end
        end
        PH_PRE_HVAL: begin
          if (!bl) begin
            if (crlf) begin
              fail_t = 1'b1;
            end else begin
              tok_t = off_q;
              lnb_t = off_q;
              ph_t  = PH_HVAL;
            end
          end
        end
        PH_HVAL: begin
          if (c == CH_CR) begin
            a_v  = 1'b1;
            a_k  = K_HVAL;
            a_e  = lnb_q + OFF_ONE;
            ph_t = PH_H_LF;
          end else if (!bl) begin
            lnb_t = off_q;
          end
        end
        PH_H_LF: begin
          if (c == CH_LF) ph_t = PH_H_START;
          else fail_t = 1'b1;
        end
        PH_H_END_LF: begin
          if (c == CH_LF) begin
            tok_t = off_q + OFF_ONE;
            ph_t  = PH_BODY;
          end else begin
            fail_t = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (fail_t) begin
        a_v  = 1'b1;
        a_k  = line_phase(phase_q) ? K_LERR : K_HERR;
        a_b  = off_q;
        a_e  = off_q;
        a_f  = 1'b1;
        ph_t = PH_DONE;
      end
    end
  end

  always_comb begin
    b_v = 1'b0;
    b_k = K_BODY;
    b_b = off_n;
    b_e = off_n;
    if (req_i.final_byte) begin
      if (ph_t == PH_BODY) begin
        b_v = 1'b1;
        b_b = tok_t;
      end else if (ph_t != PH_DONE) begin
        b_v = 1'b1;
        b_k = line_phase(ph_t) ? K_LERR : K_HERR;
      end
    end
  end

  assign a_b_x = {{SPAN_OFF_W{1'b0}}, a_b};
  assign a_e_x = {{SPAN_OFF_W{1'b0}}, a_e};
  assign b_b_x = {{SPAN_OFF_W{1'b0}}, b_b};
  assign b_e_x = {{SPAN_OFF_W{1'b0}}, b_e};

  assign ev_a = '{kind: a_k, span_begin: a_b_x[SPAN_OFF_W-1:0],
                  span_end: a_e_x[SPAN_OFF_W-1:0], fin: a_f};
  assign ev_b = '{kind: b_k, span_begin: b_b_x[SPAN_OFF_W-1:0],
                  span_end: b_e_x[SPAN_OFF_W-1:0], fin: 1'b1};

  assign push_valid_o   = accept && (a_v || b_v);
  assign push_rec_o.two = a_v && b_v;
  assign push_rec_o.ev0 = a_v ? ev_a : ev_b;
  assign push_rec_o.ev1 = ev_b;

  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    tok_d   = tok_q;
    lnb_d   = lnb_q;
    if (accept) begin
      if (req_i.final_byte) begin
        phase_d = PH_PRE;
        off_d   = '0;
        tok_d   = '0;
        lnb_d   = '0;
      end else begin
        phase_d = ph_t;
        off_d   = off_n;
        tok_d   = tok_t;
        lnb_d   = lnb_t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PRE;
      off_q   <= '0;
      tok_q   <= '0;
      lnb_q   <= '0;
    end else begin
      phase_q <= phase_d;
      off_q   <= off_d;
      tok_q   <= tok_d;
      lnb_q   <= lnb_d;
    end
  end

endmodule

>>> rtl/hrsp_queue.sv
module hrsp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  hrsp_pkg::rec_t push_rec_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output hrsp_pkg::rec_t pop_rec_o,
  input  logic           pop_ready_i
);
  import hrsp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

  rec_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_rec_o    = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = do_push ? wr_q + PTR_ONE : wr_q;
    rd_d  = do_pop ? rd_q + PTR_ONE : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_ONE;
    else if (do_pop && !do_push) cnt_d = cnt_q - CNT_ONE;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/hrsp_back.sv
module hrsp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  hrsp_pkg::rec_t pop_rec_i,
  output logic           pop_ready_o,
  hrsp_out_if.source     evt_o
);
  import hrsp_pkg::*;

  logic  out_v_q, out_v_d;
  span_t out_q, out_d;
  logic  sec_v_q, sec_v_d;
  span_t sec_q, sec_d;
  logic  slot_free;

  assign slot_free   = !out_v_q || evt_o.ready;
  assign pop_ready_o = slot_free && !sec_v_q;

  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    sec_v_d = sec_v_q;
    sec_d   = sec_q;
    if (slot_free) begin
      if (sec_v_q) begin
        out_v_d = 1'b1;
        out_d   = sec_q;
        sec_v_d = 1'b0;
      end else if (pop_valid_i) begin
        out_v_d = 1'b1;
        out_d   = pop_rec_i.ev0;
        sec_v_d = pop_rec_i.two;
        sec_d   = pop_rec_i.ev1;
      end else begin
        out_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sec_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sec_v_q <= sec_v_d;
    end
  end

  assign evt_o.valid       = out_v_q;
  assign evt_o.span_kind   = out_q.kind;
  assign evt_o.span_begin  = out_q.span_begin;
  assign evt_o.span_end    = out_q.span_end;
  assign evt_o.final_event = out_q.fin;

endmodule

>>> rtl/http_request_span_parser.sv
// Each span is written into the queue, then into the output register that drives evt_o.
// Throughput: one byte per cycle on req_i while the queue has room; one span per cycle
// on evt_o while ready; the two spans of one byte share one of the four queue entries.
// Reset: parse phase, offsets, queue pointers and output valid clear asynchronously;
// the parser starts a new request after reset and after every final byte.
module http_request_span_parser #(
  parameter int unsigned OFFSET_WIDTH = hrsp_pkg::OFFSET_WIDTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrsp_in_if.sink    req_i,
  hrsp_out_if.source evt_o
);
  import hrsp_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  rec_t push_rec, pop_rec;

  hrsp_front #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_rec_o   (push_rec)
  );

  hrsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_rec_i   (push_rec),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_rec_o    (pop_rec),
    .pop_ready_i  (pop_ready)
  );

  hrsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_rec_i   (pop_rec),
    .pop_ready_o (pop_ready),
    .evt_o       (evt_o)
  );

endmodule

>>> sim/http_request_span_parser_tb.sv
module http_request_span_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hrsp_pkg::*;

  localparam int unsigned OFF_W = OFFSET_WIDTH_DEFAULT;
  localparam logic [OFF_W-1:0] OFF_MAX = '1;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_ITEMS = 300;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AFTER = 40;
  localparam span_t NO_SPAN = '0;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    span_t      span;
  } dir_row_t;

  localparam dir_row_t DIRECTED [26] = '{
    '{8'hFF,    1'b0, 1'b1, '{K_LERR, 16'd0, 16'd0, 1'b1}},
    '{8'h00,    1'b1, 1'b0, NO_SPAN},
    '{CH_A,     1'b1, 1'b1, '{K_LERR, 16'd1, 16'd1, 1'b1}},
    '{CH_A,     1'b0, 1'b0, NO_SPAN},
    '{CH_SP,    1'b0, 1'b0, NO_SPAN},
    '{CH_QUEST, 1'b0, 1'b0, NO_SPAN},
    '{CH_EQ,    1'b1, 1'b1, '{K_LERR, 16'd3, 16'd3, 1'b1}},
    '{CH_A,     1'b0, 1'b0, NO_SPAN},
    '{CH_TAB,   1'b0, 1'b0, NO_SPAN},
    '{CH_QUEST, 1'b0, 1'b0, NO_SPAN},
    '{"k",      1'b0, 1'b0, NO_SPAN},
    '{CH_EQ,    1'b0, 1'b0, NO_SPAN},
    '{"v",      1'b0, 1'b0, NO_SPAN},
    '{CH_SP,    1'b0, 1'b0, NO_SPAN},
    '{CH_H,     1'b0, 1'b0, NO_SPAN},
    '{CH_SLASH, 1'b0, 1'b0, NO_SPAN},
    '{CH_9,     1'b0, 1'b0, NO_SPAN},
    '{CH_CR,    1'b0, 1'b0, NO_SPAN},
    '{CH_LF,    1'b0, 1'b0, NO_SPAN},
    '{"K",      1'b0, 1'b0, NO_SPAN},
    '{CH_COLON, 1'b0, 1'b0, NO_SPAN},
    '{"V",      1'b0, 1'b0, NO_SPAN},
    '{CH_CR,    1'b0, 1'b0, NO_SPAN},
    '{CH_LF,    1'b0, 1'b0, NO_SPAN},
    '{CH_CR,    1'b0, 1'b0, NO_SPAN},
    '{CH_LF,    1'b1, 1'b0, NO_SPAN}
  };

  localparam logic [7:0] TWEAK [8] = '{
    CH_CR, CH_LF, CH_SP, CH_EQ, CH_AMP, CH_QUEST, CH_COLON, CH_SLASH
  };

  logic clk_i;
  logic rst_ni;

  hrsp_in_if  req ();
  hrsp_out_if evt ();

  http_request_span_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .evt_o  (evt)
  );

  phase_e           ph;
  logic [OFF_W-1:0] offs;
  logic [OFF_W-1:0] tok;
  logic [OFF_W-1:0] lnb;
  span_t            step_spans[$];
  span_t            expected_spans[$];
  logic [7:0]       msg[$];
  int               live_items;
  int               spans_seen;
  bit               calm;
  bit               failed;

  function automatic void clear_parse();
    ph   = PH_PRE;
    offs = '0;
    tok  = '0;
    lnb  = '0;
  endfunction

  function automatic void add_span(logic [3:0] k, logic [OFF_W-1:0] b, logic [OFF_W-1:0] e,
                                   logic f);
    span_t s;
    s.kind       = k;
    s.span_begin = b;
    s.span_end   = e;
    s.fin        = f;
    if (step_spans.size() < 2) step_spans.push_back(s);
  endfunction

  function automatic void raise_error(logic [OFF_W-1:0] at);
    if (ph <= PH_RL_LF) add_span(K_LERR, at, at, 1'b1);
    else add_span(K_HERR, at, at, 1'b1);
    ph = PH_DONE;
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic f);
    logic             bl;
    logic             crlf;
    logic [OFF_W-1:0] at;
    bl   = (c == CH_SP) || (c == CH_TAB);
    crlf = (c == CH_CR) || (c == CH_LF);
    at   = offs;
    step_spans.delete();
    if (at == OFF_MAX) begin
      if (ph != PH_DONE) begin
        add_span(K_HERR, OFF_MAX, OFF_MAX, 1'b1);
        ph = PH_DONE;
      end
    end else begin
      case (ph)
        PH_PRE: begin
          if (!bl) begin
            if (c >= CH_A && c <= CH_Z) begin
              tok = at;
              ph  = PH_METHOD;
            end else raise_error(at);
          end
        end
        PH_METHOD: begin
          if (bl) begin
            add_span(K_METHOD, tok, at, 1'b0);
            ph = PH_PRE_URL;
          end
        end
        PH_PRE_URL: begin
          if (!bl) begin
            if (crlf) raise_error(at);
            else if (c == CH_QUEST) begin
              add_span(K_URL, at, at, 1'b0);
              ph = PH_QSTART;
            end else begin
              tok = at;
              ph  = PH_URL;
            end
          end
        end
        PH_URL: begin
          if (bl) begin
            add_span(K_URL, tok, at, 1'b0);
            ph = PH_PRE_PROTO;
          end else if (c == CH_QUEST) begin
            add_span(K_URL, tok, at, 1'b0);
            ph = PH_QSTART;
          end
        end
        PH_QSTART: begin
          if (crlf || c == CH_EQ) raise_error(at);
          else if (bl) ph = PH_PRE_PROTO;
          else begin
            tok = at;
            ph  = PH_QKEY;
          end
        end
        PH_QKEY: begin
          if (c == CH_EQ) begin
            add_span(K_QKEY, tok, at, 1'b0);
            tok = at + 1'b1;
            ph  = PH_QVAL0;
          end
        end
        PH_QVAL0: begin
          if (bl || c == CH_AMP) raise_error(at);
          else ph = PH_QVAL;
        end
        PH_QVAL: begin
          if (bl) begin
            add_span(K_QVAL, tok, at, 1'b0);
            ph = PH_PRE_PROTO;
          end else if (c == CH_AMP) begin
            add_span(K_QVAL, tok, at, 1'b0);
            ph = PH_QSTART;
          end
        end
        PH_PRE_PROTO: begin
          if (!bl) begin
            if (c == CH_H) begin
              tok = at;
              ph  = PH_PROTO;
            end else raise_error(at);
          end
        end
        PH_PROTO: begin
          if (c == CH_SLASH) begin
            add_span(K_PROTO, tok, at, 1'b0);
            ph = PH_VER0;
          end
        end
        PH_VER0: begin
          if (c >= CH_0 && c <= CH_9) begin
            tok = at;
            ph  = PH_VER;
          end else raise_error(at);
        end
        PH_VER: begin
          if (c == CH_CR) begin
            add_span(K_VER, tok, at, 1'b0);
            ph = PH_RL_LF;
          end
        end
        PH_RL_LF: begin
          if (c == CH_LF) ph = PH_H_START;
          else raise_error(at);
        end
        PH_H_START: begin
          if (!bl) begin
            if (c == CH_CR) ph = PH_H_END_LF;
            else if (c == CH_LF) raise_error(at);
            else begin
              tok = at;
              lnb = at;
              ph  = PH_HKEY;
            end
          end
        end
        PH_HKEY: begin
          if (c == CH_COLON) begin
            add_span(K_HKEY, tok, lnb + 1'b1, 1'b0);
            ph = PH_PRE_HVAL;
          end else if (!bl) lnb = at;
        end
        PH_PRE_HVAL: begin
          if (!bl) begin
            if (crlf) raise_error(at);
            else begin
              tok = at;
              lnb = at;
              ph  = PH_HVAL;
            end
          end
        end
        PH_HVAL: begin
          if (c == CH_CR) begin
            add_span(K_HVAL, tok, lnb + 1'b1, 1'b0);
            ph = PH_H_LF;
          end else if (!bl) lnb = at;
        end
        PH_H_LF: begin
          if (c == CH_LF) ph = PH_H_START;
          else raise_error(at);
        end
        PH_H_END_LF: begin
          if (c == CH_LF) begin
            tok = at + 1'b1;
            ph  = PH_BODY;
          end else raise_error(at);
        end
        default: ;
      endcase
      offs = at + 1'b1;
    end
    if (f) begin
      if (ph == PH_BODY) add_span(K_BODY, tok, offs, 1'b1);
      else if (ph != PH_DONE) raise_error(offs);
      clear_parse();
    end
  endfunction

  function automatic logic [7:0] letter(bit upper);
    return (upper ? CH_A : 8'h61) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] blank();
    return $urandom_range(1) ? CH_SP : CH_TAB;
  endfunction

  function automatic void compose_request();
    int n;
    int cut;
    int r;
    bit with_query;
    msg.delete();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(8, 1)) msg.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(2)) msg.push_back(blank());
    msg.push_back(letter(1));
    repeat ($urandom_range(3)) msg.push_back(letter(1));
    repeat ($urandom_range(2, 1)) msg.push_back(blank());
    with_query = $urandom_range(1);
    repeat ($urandom_range(4, with_query ? 0 : 1))
      msg.push_back($urandom_range(3) == 0 ? CH_SLASH : letter(0));
    if (with_query) begin
      msg.push_back(CH_QUEST);
      n = $urandom_range(2);
      for (int i = 0; i < n; i++) begin
        if (i != 0) msg.push_back(CH_AMP);
        repeat ($urandom_range(7) == 0 ? 0 : $urandom_range(3, 1)) msg.push_back(letter(0));
        msg.push_back(CH_EQ);
        repeat ($urandom_range(7) == 0 ? 0 : $urandom_range(3, 1)) msg.push_back(letter(0));
      end
    end
    repeat ($urandom_range(2, 1)) msg.push_back(blank());
    msg.push_back(CH_H);
    repeat ($urandom_range(3)) msg.push_back(letter(1));
    msg.push_back(CH_SLASH);
    msg.push_back(CH_0 + 8'($urandom_range(9)));
    repeat ($urandom_range(2)) msg.push_back($urandom_range(1) ? 8'h2E : CH_0 + 8'd1);
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
    repeat ($urandom_range(3)) begin
      repeat ($urandom_range(1)) msg.push_back(blank());
      repeat ($urandom_range(4, 1))
        msg.push_back($urandom_range(4) == 0 ? blank() : letter($urandom_range(1)));
      msg.push_back(CH_COLON);
      repeat ($urandom_range(2)) msg.push_back(blank());
      repeat ($urandom_range(5, 1)) begin
        r = $urandom_range(9);
        msg.push_back(r < 2 ? blank() : (r == 2 ? CH_COLON : letter($urandom_range(1))));
      end
      repeat ($urandom_range(2)) msg.push_back(blank());
      msg.push_back(CH_CR);
      msg.push_back(CH_LF);
    end
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
    repeat ($urandom_range(6)) msg.push_back(8'($urandom));
    r = $urandom_range(99);
    if (r < 20) begin
      msg[$urandom_range(msg.size() - 1)] =
        $urandom_range(1) ? 8'($urandom) : TWEAK[$urandom_range(7)];
    end else if (r < 35) begin
      cut = $urandom_range(msg.size() - 1, 1);
      while (msg.size() > cut) void'(msg.pop_back());
    end
  endfunction

  task automatic send_byte(logic [7:0] data, logic fin, logic typed, span_t hand_span);
    logic rdy;
    while (!calm && $urandom_range(99) < 31) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.data_byte  <= data;
    req.final_byte <= fin;
    do begin
      @(negedge clk_i);
      rdy = req.ready;
      @(posedge clk_i);
    end while (rdy !== 1'b1);
    if (ph != PH_DONE) live_items++;
    predict_byte(data, fin);
    if (typed) expected_spans.push_back(hand_span);
    else foreach (step_spans[k]) expected_spans.push_back(step_spans[k]);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_500_000;
    $display("http_request_span_parser_tb failed");
    $finish;
  end

  initial begin : span_sink
    logic  v;
    logic  r;
    span_t got;
    span_t want;
    int    hold_left;
    bit    held;
    hold_left = 0;
    held      = 0;
    evt.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      v              = evt.valid;
      r              = evt.ready;
      got.kind       = evt.span_kind;
      got.span_begin = evt.span_begin;
      got.span_end   = evt.span_end;
      got.fin        = evt.final_event;
      @(posedge clk_i);
      if (v === 1'b1 && r === 1'b1) begin
        spans_seen++;
        if (expected_spans.size() == 0) begin
          $error("unexpected span: kind %0d begin %0d end %0d final %0d",
                 got.kind, got.span_begin, got.span_end, got.fin);
          failed = 1;
        end else begin
          want = expected_spans.pop_front();
          if (got.kind !== want.kind) begin
            $error("span_kind: expected %0d, got %0d", want.kind, got.kind);
            failed = 1;
          end
          if (got.span_begin !== want.span_begin) begin
            $error("span_begin: expected %0d, got %0d", want.span_begin, got.span_begin);
            failed = 1;
          end
          if (got.span_end !== want.span_end) begin
            $error("span_end: expected %0d, got %0d", want.span_end, got.span_end);
            failed = 1;
          end
          if (got.fin !== want.fin) begin
            $error("final_event: expected %0d, got %0d", want.fin, got.fin);
            failed = 1;
          end
        end
      end
      if (!held && spans_seen >= HOLD_AFTER) begin
        held      = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        evt.ready <= 1'b0;
      end else begin
        evt.ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin : request_source
    failed         = 0;
    calm           = 0;
    spans_seen     = 0;
    live_items     = 0;
    req.valid      <= 1'b0;
    req.data_byte  <= 8'h00;
    req.final_byte <= 1'b0;
    rst_ni         <= 1'b0;
    clear_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].data, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].span);

    live_items = 0;
    while (live_items < RANDOM_ITEMS - CALM_ITEMS) begin
      compose_request();
      foreach (msg[j]) send_byte(msg[j], j == msg.size() - 1, 1'b0, NO_SPAN);
    end

    // keep both sides streaming for the last requests
    calm = 1;
    while (live_items < RANDOM_ITEMS) begin
      compose_request();
      foreach (msg[j]) send_byte(msg[j], j == msg.size() - 1, 1'b0, NO_SPAN);
    end
    calm = 0;
    req.valid <= 1'b0;

    while (expected_spans.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (failed == 0) begin
      $display("http_request_span_parser_tb passed");
    end else begin
      $display("http_request_span_parser_tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hrsp_pkg.sv
rtl/hrsp_in_if.sv
rtl/hrsp_out_if.sv
rtl/hrsp_front.sv
rtl/hrsp_queue.sv
rtl/hrsp_back.sv
rtl/http_request_span_parser.sv
sim/http_request_span_parser_tb.sv
